FILE: rtl/triangle_face_normal_macros.svh
// ----------------------------------------------------------------------------
// Triangle face normal assertion macros
// Shared concurrent assertion forms; clock and reset come from the module.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_FACE_NORMAL_MACROS_SVH
`define TRIANGLE_FACE_NORMAL_MACROS_SVH

// property must hold at every edge outside reset
`define TFN_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// condition must never be seen outside reset
`define TFN_ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

FILE: rtl/tfn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle face normal package
// Field widths, arithmetic widths, codes and shared transaction types.
// ----------------------------------------------------------------------------
package tfn_pkg;

   // field widths
   localparam int COORD_W = 24;
   localparam int IDX_W   = 12;
   localparam int TAG_W   = 20;
   localparam int NORM_W  = 18;
   localparam int LEN_W   = 40;
   localparam int MINL_W  = 17;

   // arithmetic widths
   localparam int DIFF_W    = COORD_W + 1;
   localparam int PROD_W    = 2 * DIFF_W;
   localparam int CROSS_W   = PROD_W + 1;
   localparam int MAG_W     = PROD_W;
   localparam int HALF_W    = MAG_W / 2;
   localparam int SQ_W      = 2 * MAG_W;
   localparam int FRAC_SH   = 32;
   localparam int RAD_W     = SQ_W - FRAC_SH;
   localparam int ROOT_W    = RAD_W / 2;
   localparam int REM_W     = ROOT_W + 2;
   localparam int DEN_W     = ROOT_W;
   localparam int QUO_W     = 17;
   localparam int SHIFTED_W = DEN_W + QUO_W;

   localparam logic [QUO_W-1:0]  NORM_MAX        = 17'd65536;
   localparam logic [MINL_W-1:0] MIN_LENGTH_RESET = 17'd66;

   // request codes
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_FACE = 1'b1;

   // register file
   localparam int               CSR_ADDR_W     = 2;
   localparam int               CSR_DATA_W     = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_LENGTH = 2'd0;

   // decoupling queue
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } vertex_type;

   typedef struct packed {
      logic [TAG_W-1:0] tag;
      vertex_type       a;
      vertex_type       b;
      vertex_type       c;
   } face_type;

endpackage

FILE: rtl/tfn_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle face normal front end
// Accepts transactions, writes the vertex store on loads, reads three corners
// on faces and hands the face to the queue.
// ----------------------------------------------------------------------------
module tfn_front
   import tfn_pkg::*;
#(
   parameter int VERTEX_DEPTH = 4096
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_type,
   input  logic [IDX_W-1:0]          req_vertex_slot,
   input  logic signed [COORD_W-1:0] req_coord_x,
   input  logic signed [COORD_W-1:0] req_coord_y,
   input  logic signed [COORD_W-1:0] req_coord_z,
   input  logic [IDX_W-1:0]          req_corner_a,
   input  logic [IDX_W-1:0]          req_corner_b,
   input  logic [IDX_W-1:0]          req_corner_c,
   input  logic [TAG_W-1:0]          req_face_tag,
   input  logic [FIFO_CNT_W-1:0]     fifo_count,
   output logic                      push,
   output face_type                  push_data
);

   localparam int AW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;

   vertex_type mem_a [VERTEX_DEPTH];
   vertex_type mem_b [VERTEX_DEPTH];
   vertex_type mem_c [VERTEX_DEPTH];

   vertex_type rd_a_ff, rd_b_ff, rd_c_ff;
   vertex_type wr_vertex;

   logic                  f1_valid_ff, f1_valid_in;
   logic [TAG_W-1:0]      f1_tag_ff;
   logic [2:0]            f1_zero_ff, f1_zero_in;

   logic                  accept, load_en, face_en;
   logic [31:0]           slot_ext, a_ext, b_ext, c_ext;
   logic [FIFO_CNT_W-1:0] credit;

   assign credit    = fifo_count + FIFO_CNT_W'(f1_valid_ff);
   assign req_stall = credit >= FIFO_CNT_W'(FIFO_DEPTH);
   assign accept    = req_valid && !req_stall;

   assign slot_ext = 32'(req_vertex_slot);
   assign a_ext    = 32'(req_corner_a);
   assign b_ext    = 32'(req_corner_b);
   assign c_ext    = 32'(req_corner_c);

   assign load_en = accept && req_type == REQ_LOAD && slot_ext < 32'(VERTEX_DEPTH);
   assign face_en = accept && req_type == REQ_FACE;

   assign wr_vertex = '{x: req_coord_x, y: req_coord_y, z: req_coord_z};

   always_ff @(posedge clock) begin
      if (load_en) begin
         mem_a[slot_ext[AW-1:0]] <= wr_vertex;
         mem_b[slot_ext[AW-1:0]] <= wr_vertex;
         mem_c[slot_ext[AW-1:0]] <= wr_vertex;
      end
   end

   always_ff @(posedge clock) begin
      if (face_en) begin
         rd_a_ff <= mem_a[a_ext[AW-1:0]];
         rd_b_ff <= mem_b[b_ext[AW-1:0]];
         rd_c_ff <= mem_c[c_ext[AW-1:0]];
      end
   end

   assign f1_valid_in = face_en;
   assign f1_zero_in  = {a_ext >= 32'(VERTEX_DEPTH),
                         b_ext >= 32'(VERTEX_DEPTH),
                         c_ext >= 32'(VERTEX_DEPTH)};

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else begin
         f1_valid_ff <= f1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (face_en) begin
         f1_tag_ff  <= req_face_tag;
         f1_zero_ff <= f1_zero_in;
      end
   end

   assign push           = f1_valid_ff;
   assign push_data.tag  = f1_tag_ff;
   assign push_data.a    = f1_zero_ff[2] ? '0 : rd_a_ff;
   assign push_data.b    = f1_zero_ff[1] ? '0 : rd_b_ff;
   assign push_data.c    = f1_zero_ff[0] ? '0 : rd_c_ff;

endmodule

FILE: rtl/tfn_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle face normal queue
// Short queue of face transactions between front end and arithmetic back end.
// ----------------------------------------------------------------------------
`include "triangle_face_normal_macros.svh"

module tfn_fifo
   import tfn_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  face_type              push_data,
   input  logic                  pop,
   output face_type              pop_data,
   output logic                  empty,
   output logic [FIFO_CNT_W-1:0] count
);

   face_type                entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   count_ff, count_in;

   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = entry_ff[rd_ptr_ff];
   assign empty    = count_ff == '0;
   assign count    = count_ff;

   `TFN_ASSERT_NEVER(queue_overflow, push && !pop && count_ff == FIFO_CNT_W'(FIFO_DEPTH), "queue overflow")
   `TFN_ASSERT_NEVER(queue_underflow, pop && count_ff == '0, "queue underflow")

endmodule

FILE: rtl/tfn_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle face normal back end
// Pipelined cross product, length by digit-serial square root stages and
// normal components by restoring division stages.
// ----------------------------------------------------------------------------
`include "triangle_face_normal_macros.svh"

module tfn_back
   import tfn_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     empty,
   input  face_type                 pop_data,
   output logic                     pop,
   input  logic [MINL_W-1:0]        min_length,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [TAG_W-1:0]         rsp_result_tag,
   output logic signed [NORM_W-1:0] rsp_normal_x,
   output logic signed [NORM_W-1:0] rsp_normal_y,
   output logic signed [NORM_W-1:0] rsp_normal_z,
   output logic [LEN_W-1:0]         rsp_cross_length
);

   typedef logic [2:0][MAG_W-1:0] mag_vec_type;

   typedef struct packed {
      logic [TAG_W-1:0]         tag;
      logic signed [DIFF_W-1:0] ux, uy, uz, vx, vy, vz;
   } diff_type;

   typedef struct packed {
      logic [TAG_W-1:0]         tag;
      logic signed [PROD_W-1:0] p0, p1, p2, p3, p4, p5;
   } prod_type;

   typedef struct packed {
      logic [TAG_W-1:0]          tag;
      logic signed [CROSS_W-1:0] n0, n1, n2;
   } cross_type;

   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic [2:0]       sign;
      mag_vec_type      mag;
   } mag_type;

   typedef struct packed {
      logic [TAG_W-1:0]      tag;
      logic [2:0]            sign;
      mag_vec_type           mag;
      logic [2:0][MAG_W-1:0] hh, hl, ll;
   } part_type;

   typedef struct packed {
      logic [TAG_W-1:0]     tag;
      logic [2:0]           sign;
      mag_vec_type          mag;
      logic [2:0][SQ_W-1:0] sq;
   } square_type;

   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic [2:0]       sign;
      mag_vec_type      mag;
      logic [SQ_W-1:0]  sum;
   } sum_type;

   typedef struct packed {
      logic [TAG_W-1:0]  tag;
      logic [2:0]        sign;
      mag_vec_type       mag;
      logic [RAD_W-1:0]  rad;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sqrt_type;

   typedef struct packed {
      logic [TAG_W-1:0]       tag;
      logic [2:0]             sign;
      logic [ROOT_W-1:0]      len;
      logic [DEN_W-1:0]       den;
      logic [2:0]             ovf;
      mag_vec_type            rem;
      logic [2:0][QUO_W-1:0]  quo;
   } div_type;

   function automatic sqrt_type sqrt_step(input sqrt_type s);
      sqrt_type         r;
      logic [REM_W+1:0] cur;
      logic [REM_W+1:0] trial;
      r     = s;
      cur   = {s.rem, s.rad[RAD_W-1 -: 2]};
      trial = (REM_W+2)'({s.root, 2'b01});
      r.rad = {s.rad[RAD_W-3:0], 2'b00};
      if (cur >= trial) begin
         r.rem  = REM_W'(cur - trial);
         r.root = {s.root[ROOT_W-2:0], 1'b1};
      end else begin
         r.rem  = cur[REM_W-1:0];
         r.root = {s.root[ROOT_W-2:0], 1'b0};
      end
      return r;
   endfunction

   function automatic div_type div_step(input div_type s, input int k);
      div_type              r;
      logic [SHIFTED_W-1:0] shifted;
      r       = s;
      shifted = SHIFTED_W'(s.den) << k;
      for (int i = 0; i < 3; i++) begin
         if (!s.ovf[i] && SHIFTED_W'(s.rem[i]) >= shifted) begin
            r.rem[i]    = MAG_W'(SHIFTED_W'(s.rem[i]) - shifted);
            r.quo[i][k] = 1'b1;
         end
      end
      return r;
   endfunction

   logic adv;

   logic       diff_v_ff, prod_v_ff, cross_v_ff, mag_v_ff, part_v_ff, sq_v_ff, sum_v_ff;
   logic       dset_v_ff;
   diff_type   diff_ff, diff_in;
   prod_type   prod_ff, prod_in;
   cross_type  cross_ff, cross_in;
   mag_type    mag_ff, mag_in;
   part_type   part_ff, part_in;
   square_type sq_ff, sq_in;
   sum_type    sum_ff, sum_in;

   logic [ROOT_W-1:0] rt_v_ff;
   sqrt_type          rt_src [ROOT_W];
   sqrt_type          rt_in  [ROOT_W];
   sqrt_type          rt_ff  [ROOT_W];

   div_type           dset_ff, dset_in;
   logic [QUO_W-1:0]  dv_v_ff;
   div_type           dv_src [QUO_W];
   div_type           dv_in  [QUO_W];
   div_type           dv_ff  [QUO_W];

   logic                     rsp_valid_ff;
   logic [TAG_W-1:0]         rsp_result_tag_ff;
   logic signed [NORM_W-1:0] rsp_normal_x_ff, rsp_normal_y_ff, rsp_normal_z_ff;
   logic [LEN_W-1:0]         rsp_cross_length_ff;
   logic signed [NORM_W-1:0] norm_in [3];

   assign adv = !(rsp_valid_ff && rsp_stall);
   assign pop = adv && !empty;

   // differences
   always_comb begin
      diff_in.tag = pop_data.tag;
      diff_in.ux  = DIFF_W'(pop_data.b.x) - DIFF_W'(pop_data.a.x);
      diff_in.uy  = DIFF_W'(pop_data.b.y) - DIFF_W'(pop_data.a.y);
      diff_in.uz  = DIFF_W'(pop_data.b.z) - DIFF_W'(pop_data.a.z);
      diff_in.vx  = DIFF_W'(pop_data.c.x) - DIFF_W'(pop_data.a.x);
      diff_in.vy  = DIFF_W'(pop_data.c.y) - DIFF_W'(pop_data.a.y);
      diff_in.vz  = DIFF_W'(pop_data.c.z) - DIFF_W'(pop_data.a.z);
   end

   // products
   always_comb begin
      prod_in.tag = diff_ff.tag;
      prod_in.p0  = diff_ff.uy * diff_ff.vz;
      prod_in.p1  = diff_ff.uz * diff_ff.vy;
      prod_in.p2  = diff_ff.uz * diff_ff.vx;
      prod_in.p3  = diff_ff.ux * diff_ff.vz;
      prod_in.p4  = diff_ff.ux * diff_ff.vy;
      prod_in.p5  = diff_ff.uy * diff_ff.vx;
   end

   // cross product
   always_comb begin
      cross_in.tag = prod_ff.tag;
      cross_in.n0  = CROSS_W'(prod_ff.p0) - CROSS_W'(prod_ff.p1);
      cross_in.n1  = CROSS_W'(prod_ff.p2) - CROSS_W'(prod_ff.p3);
      cross_in.n2  = CROSS_W'(prod_ff.p4) - CROSS_W'(prod_ff.p5);
   end

   // sign and magnitude
   always_comb begin
      logic signed [CROSS_W-1:0] neg0, neg1, neg2;
      neg0 = -cross_ff.n0;
      neg1 = -cross_ff.n1;
      neg2 = -cross_ff.n2;
      mag_in.tag    = cross_ff.tag;
      mag_in.sign   = {cross_ff.n2[CROSS_W-1], cross_ff.n1[CROSS_W-1], cross_ff.n0[CROSS_W-1]};
      mag_in.mag[0] = cross_ff.n0[CROSS_W-1] ? neg0[MAG_W-1:0] : cross_ff.n0[MAG_W-1:0];
      mag_in.mag[1] = cross_ff.n1[CROSS_W-1] ? neg1[MAG_W-1:0] : cross_ff.n1[MAG_W-1:0];
      mag_in.mag[2] = cross_ff.n2[CROSS_W-1] ? neg2[MAG_W-1:0] : cross_ff.n2[MAG_W-1:0];
   end

   // partial products of the squares
   always_comb begin
      part_in.tag  = mag_ff.tag;
      part_in.sign = mag_ff.sign;
      part_in.mag  = mag_ff.mag;
      for (int i = 0; i < 3; i++) begin
         part_in.hh[i] = mag_ff.mag[i][MAG_W-1:HALF_W] * mag_ff.mag[i][MAG_W-1:HALF_W];
         part_in.hl[i] = mag_ff.mag[i][MAG_W-1:HALF_W] * mag_ff.mag[i][HALF_W-1:0];
         part_in.ll[i] = mag_ff.mag[i][HALF_W-1:0] * mag_ff.mag[i][HALF_W-1:0];
      end
   end

   // squares
   always_comb begin
      sq_in.tag  = part_ff.tag;
      sq_in.sign = part_ff.sign;
      sq_in.mag  = part_ff.mag;
      for (int i = 0; i < 3; i++) begin
         sq_in.sq[i] = (SQ_W'(part_ff.hh[i]) << (2 * HALF_W))
                     + (SQ_W'(part_ff.hl[i]) << (HALF_W + 1))
                     + SQ_W'(part_ff.ll[i]);
      end
   end

   // sum of squares
   always_comb begin
      sum_in.tag  = sq_ff.tag;
      sum_in.sign = sq_ff.sign;
      sum_in.mag  = sq_ff.mag;
      sum_in.sum  = sq_ff.sq[0] + sq_ff.sq[1] + sq_ff.sq[2];
   end

   // square root, two radicand bits per stage
   always_comb begin
      rt_src[0].tag  = sum_ff.tag;
      rt_src[0].sign = sum_ff.sign;
      rt_src[0].mag  = sum_ff.mag;
      rt_src[0].rad  = sum_ff.sum[SQ_W-1:FRAC_SH];
      rt_src[0].rem  = '0;
      rt_src[0].root = '0;
      for (int k = 1; k < ROOT_W; k++) begin
         rt_src[k] = rt_ff[k-1];
      end
      for (int k = 0; k < ROOT_W; k++) begin
         rt_in[k] = sqrt_step(rt_src[k]);
      end
   end

   // divisor select and overflow check
   always_comb begin
      logic [DEN_W-1:0] minl;
      logic [DEN_W-1:0] len;
      minl = (min_length == '0) ? DEN_W'(1) : DEN_W'(min_length);
      len  = rt_ff[ROOT_W-1].root;
      dset_in.tag  = rt_ff[ROOT_W-1].tag;
      dset_in.sign = rt_ff[ROOT_W-1].sign;
      dset_in.len  = len;
      dset_in.den  = (len > minl) ? len : minl;
      dset_in.rem  = rt_ff[ROOT_W-1].mag;
      dset_in.quo  = '0;
      for (int i = 0; i < 3; i++) begin
         dset_in.ovf[i] = SHIFTED_W'(rt_ff[ROOT_W-1].mag[i])
                          >= (SHIFTED_W'(dset_in.den) << QUO_W);
      end
   end

   // restoring division, one quotient bit per stage
   always_comb begin
      dv_src[0] = dset_ff;
      for (int j = 1; j < QUO_W; j++) begin
         dv_src[j] = dv_ff[j-1];
      end
      for (int j = 0; j < QUO_W; j++) begin
         dv_in[j] = div_step(dv_src[j], QUO_W - 1 - j);
      end
   end

   // saturate and apply sign
   always_comb begin
      logic [QUO_W-1:0]         qsat;
      logic signed [NORM_W-1:0] qext;
      for (int i = 0; i < 3; i++) begin
         qsat = (dv_ff[QUO_W-1].ovf[i] || dv_ff[QUO_W-1].quo[i] > NORM_MAX)
                ? NORM_MAX : dv_ff[QUO_W-1].quo[i];
         qext = NORM_W'(qsat);
         norm_in[i] = dv_ff[QUO_W-1].sign[i] ? -qext : qext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         diff_v_ff    <= 1'b0;
         prod_v_ff    <= 1'b0;
         cross_v_ff   <= 1'b0;
         mag_v_ff     <= 1'b0;
         part_v_ff    <= 1'b0;
         sq_v_ff      <= 1'b0;
         sum_v_ff     <= 1'b0;
         rt_v_ff      <= '0;
         dset_v_ff    <= 1'b0;
         dv_v_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         diff_v_ff    <= pop;
         prod_v_ff    <= diff_v_ff;
         cross_v_ff   <= prod_v_ff;
         mag_v_ff     <= cross_v_ff;
         part_v_ff    <= mag_v_ff;
         sq_v_ff      <= part_v_ff;
         sum_v_ff     <= sq_v_ff;
         rt_v_ff      <= {rt_v_ff[ROOT_W-2:0], sum_v_ff};
         dset_v_ff    <= rt_v_ff[ROOT_W-1];
         dv_v_ff      <= {dv_v_ff[QUO_W-2:0], dset_v_ff};
         rsp_valid_ff <= dv_v_ff[QUO_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         diff_ff  <= diff_in;
         prod_ff  <= prod_in;
         cross_ff <= cross_in;
         mag_ff   <= mag_in;
         part_ff  <= part_in;
         sq_ff    <= sq_in;
         sum_ff   <= sum_in;
         for (int k = 0; k < ROOT_W; k++) begin
            rt_ff[k] <= rt_in[k];
         end
         dset_ff <= dset_in;
         for (int j = 0; j < QUO_W; j++) begin
            dv_ff[j] <= dv_in[j];
         end
         rsp_result_tag_ff   <= dv_ff[QUO_W-1].tag;
         rsp_normal_x_ff     <= norm_in[0];
         rsp_normal_y_ff     <= norm_in[1];
         rsp_normal_z_ff     <= norm_in[2];
         rsp_cross_length_ff <= LEN_W'(dv_ff[QUO_W-1].len);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_tag   = rsp_result_tag_ff;
   assign rsp_normal_x     = rsp_normal_x_ff;
   assign rsp_normal_y     = rsp_normal_y_ff;
   assign rsp_normal_z     = rsp_normal_z_ff;
   assign rsp_cross_length = rsp_cross_length_ff;

   `TFN_ASSERT(rsp_hold_when_stalled, rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_result_tag_ff) && $stable(rsp_normal_x_ff) && $stable(rsp_cross_length_ff), "response changed while stalled")
   `TFN_ASSERT_NEVER(normal_out_of_range, rsp_valid_ff && (rsp_normal_x_ff > 18'sd65536 || rsp_normal_x_ff < -18'sd65536 || rsp_normal_y_ff > 18'sd65536 || rsp_normal_y_ff < -18'sd65536 || rsp_normal_z_ff > 18'sd65536 || rsp_normal_z_ff < -18'sd65536), "normal component beyond unit range")

endmodule

FILE: rtl/triangle_face_normal.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle face normal
// Vertex store plus pipelined unit normal and cross product length per face.
// ----------------------------------------------------------------------------
// Usage:
//   req_* channel: req_type 0 writes vertex req_vertex_slot with coord x/y/z
//   and gives no response; req_type 1 reads corners a, b, c and gives one
//   rsp_* transaction carrying the face tag, the Q1.16 unit normal and the
//   Q.16 cross product length.
//   Throughput: loads and faces mixed, one per cycle while req_stall is low.
//   Path of a face: corner read, queue, difference to sum registers, 34
//   square root stages, divisor select, 17 division stages, output register.
//   A load is visible to a face accepted on the very next cycle.
//   rsp_stall freezes the whole arithmetic pipeline; the four-entry queue
//   absorbs faces in flight and then req_stall rises.
//   The APB port holds min_length at byte address 0 (reset value 66).
//   Reset clears all valid state; vertex store contents are undefined until
//   written.
// ----------------------------------------------------------------------------
module triangle_face_normal
   import tfn_pkg::*;
#(
   parameter int VERTEX_DEPTH = 4096
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_type,
   input  logic [IDX_W-1:0]          req_vertex_slot,
   input  logic signed [COORD_W-1:0] req_coord_x,
   input  logic signed [COORD_W-1:0] req_coord_y,
   input  logic signed [COORD_W-1:0] req_coord_z,
   input  logic [IDX_W-1:0]          req_corner_a,
   input  logic [IDX_W-1:0]          req_corner_b,
   input  logic [IDX_W-1:0]          req_corner_c,
   input  logic [TAG_W-1:0]          req_face_tag,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [TAG_W-1:0]          rsp_result_tag,
   output logic signed [NORM_W-1:0]  rsp_normal_x,
   output logic signed [NORM_W-1:0]  rsp_normal_y,
   output logic signed [NORM_W-1:0]  rsp_normal_z,
   output logic [LEN_W-1:0]          rsp_cross_length,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_W-1:0]     paddr,
   input  logic [CSR_DATA_W-1:0]     pwdata,
   output logic [CSR_DATA_W-1:0]     prdata,
   output logic                      pready
);

   logic [MINL_W-1:0]     min_length_ff, min_length_in;
   logic                  csr_write;
   logic                  push, pop, empty;
   face_type              push_data, pop_data;
   logic [FIFO_CNT_W-1:0] fifo_count;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready && paddr == CSR_MIN_LENGTH;
   assign min_length_in = csr_write ? pwdata[MINL_W-1:0] : min_length_ff;
   assign prdata    = (paddr == CSR_MIN_LENGTH) ? CSR_DATA_W'(min_length_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_length_ff <= MIN_LENGTH_RESET;
      end else begin
         min_length_ff <= min_length_in;
      end
   end

   tfn_front #(
      .VERTEX_DEPTH(VERTEX_DEPTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_vertex_slot (req_vertex_slot),
      .req_coord_x     (req_coord_x),
      .req_coord_y     (req_coord_y),
      .req_coord_z     (req_coord_z),
      .req_corner_a    (req_corner_a),
      .req_corner_b    (req_corner_b),
      .req_corner_c    (req_corner_c),
      .req_face_tag    (req_face_tag),
      .fifo_count      (fifo_count),
      .push            (push),
      .push_data       (push_data)
   );

   tfn_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty),
      .count     (fifo_count)
   );

   tfn_back u_back (
      .clock            (clock),
      .reset            (reset),
      .empty            (empty),
      .pop_data         (pop_data),
      .pop              (pop),
      .min_length       (min_length_ff),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_tag   (rsp_result_tag),
      .rsp_normal_x     (rsp_normal_x),
      .rsp_normal_y     (rsp_normal_y),
      .rsp_normal_z     (rsp_normal_z),
      .rsp_cross_length (rsp_cross_length)
   );

endmodule
